### rtl/core/rql_pkg.sv
// ----------------------------------------------------------------------------
// rql_pkg
// Shared widths, constants and controller/datapath command and status types
// for the reaction quotient likelihood block.
// ----------------------------------------------------------------------------
`default_nettype none

package rql_pkg;

    localparam int COEFF_W = 5;
    localparam int CONC_W  = 48;
    localparam int KEQ_W   = 32;
    localparam int PROD_W  = 64;
    localparam int OUT_W   = 64;
    localparam int HALF_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = PROD_W + CONC_W;
    localparam int DIV_STEPS_W = 6;

    localparam logic [PROD_W-1:0] ONE_Q16 = PROD_W'(64'h1_0000);

    typedef struct packed {
        logic       capture;
        logic       load_ops;
        logic       mul_issue;
        logic [1:0] pp_idx;
        logic       write_back;
        logic       div_init;
        logic       div_step;
        logic       finish;
    } rql_cmd_t;

    typedef struct packed {
        logic reps_zero;
        logic last_item;
        logic k_mode;
        logic quot_ovf;
    } rql_status_t;

endpackage : rql_pkg

`default_nettype wire

### rtl/core/rql_in_if.sv
// ----------------------------------------------------------------------------
// rql_in_if
// Input channel: one sparse stoichiometry entry per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rql_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [rql_pkg::COEFF_W-1:0]  coefficient;
    logic        [rql_pkg::CONC_W-1:0]   concentration;
    logic        [rql_pkg::KEQ_W-1:0]    equilibrium_constant;
    logic                                last_of_reaction;

    modport source (
        output valid, coefficient, concentration, equilibrium_constant, last_of_reaction,
        input  ready
    );
    modport sink (
        input  valid, coefficient, concentration, equilibrium_constant, last_of_reaction,
        output ready
    );
endinterface : rql_in_if

`default_nettype wire

### rtl/core/rql_out_if.sv
// ----------------------------------------------------------------------------
// rql_out_if
// Result channel: one likelihood per reaction per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rql_out_if;
    logic                        valid;
    logic                        ready;
    logic [rql_pkg::OUT_W-1:0]   likelihood;
    logic                        saturated;

    modport source (
        output valid, likelihood, saturated,
        input  ready
    );
    modport sink (
        input  valid, likelihood, saturated,
        output ready
    );
endinterface : rql_out_if

`default_nettype wire

### rtl/core/rql_dp.sv
// ----------------------------------------------------------------------------
// rql_dp
// Datapath: entry capture, shared 32x32 multiplier with partial product
// accumulator, saturating product update, restoring divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rql_dp #(
    parameter int MAX_COEFF = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  rql_pkg::rql_cmd_t                   cmd,
    output rql_pkg::rql_status_t                status,
    input  wire signed [rql_pkg::COEFF_W-1:0]   coefficient,
    input  wire        [rql_pkg::CONC_W-1:0]    concentration,
    input  wire        [rql_pkg::KEQ_W-1:0]     equilibrium_constant,
    input  wire                                 last_of_reaction,
    output logic       [rql_pkg::OUT_W-1:0]     likelihood,
    output logic                                saturated
);
    import rql_pkg::*;

    logic [COEFF_W-1:0] reps_reg;
    logic               neg_reg;
    logic               last_reg;
    logic [CONC_W-1:0]  conc_reg;
    logic [KEQ_W-1:0]   k_reg;

    logic [PROD_W-1:0]  rp_reg;
    logic [PROD_W-1:0]  pp_reg;
    logic               overflow_reg;

    logic [PROD_W-1:0]  a_reg;
    logic [CONC_W-1:0]  b_reg;
    logic [PROD_W-1:0]  div_reg;
    logic               k_mode_reg;

    logic [2*HALF_W-1:0] part_reg;
    logic [1:0]          part_idx_reg;
    logic                part_valid_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic [PROD_W-1:0]  rem_reg;
    logic [PROD_W-1:0]  lo_reg;
    logic [OUT_W-1:0]   q_reg;
    logic               qsat_reg;

    logic [OUT_W-1:0]   likelihood_reg;
    logic               saturated_reg;

    logic [COEFF_W-1:0] mag;
    logic [COEFF_W-1:0] reps_init;
    logic [HALF_W-1:0]  a_half;
    logic [HALF_W-1:0]  b_half;
    logic [ACC_W-1:0]   part_shifted;
    logic               mul_sat;
    logic [PROD_W-1:0]  mul_val;
    logic [PROD_W-1:0]  num_hi;
    logic [PROD_W:0]    rem_sh;
    logic               sub_ok;

    function automatic logic [PROD_W-1:0] clamp_one(input logic [PROD_W-1:0] v);
        return (v < ONE_Q16) ? ONE_Q16 : v;
    endfunction

    // entry decode
    always_comb
    begin
        mag       = coefficient[COEFF_W-1] ? COEFF_W'(-coefficient) : COEFF_W'(coefficient);
        reps_init = (int'(mag) > MAX_COEFF) ? COEFF_W'(MAX_COEFF) : mag;
    end

    // partial product selection
    always_comb
    begin
        a_half = cmd.pp_idx[1] ? a_reg[PROD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half = cmd.pp_idx[0] ? HALF_W'(b_reg[CONC_W-1:HALF_W]) : b_reg[HALF_W-1:0];
    end

    always_comb
    begin
        case (part_idx_reg) inside
            2'd0:       part_shifted = ACC_W'(part_reg);
            2'd1, 2'd2: part_shifted = ACC_W'(part_reg) << HALF_W;
            default:    part_shifted = ACC_W'(part_reg) << (2 * HALF_W);
        endcase
    end

    // Q48.16 truncation with saturation
    always_comb
    begin
        mul_sat = |acc_reg[ACC_W-1:PROD_W+FRAC_W];
        mul_val = mul_sat ? {PROD_W{1'b1}} : acc_reg[PROD_W+FRAC_W-1:FRAC_W];
        num_hi  = acc_reg[ACC_W-1:ACC_W-PROD_W];
    end

    // one restoring division step
    always_comb
    begin
        rem_sh = {rem_reg, lo_reg[PROD_W-1]};
        sub_ok = rem_sh[PROD_W] || (rem_sh[PROD_W-1:0] >= div_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg         <= ONE_Q16;
            pp_reg         <= ONE_Q16;
            overflow_reg   <= 1'b0;
            k_mode_reg     <= 1'b0;
            part_valid_reg <= 1'b0;
        end
        else
        begin
            part_valid_reg <= cmd.mul_issue;
            if (cmd.load_ops)
            begin
                k_mode_reg <= (reps_reg == '0);
            end
            if (cmd.write_back)
            begin
                if (neg_reg)
                begin
                    rp_reg <= mul_val;
                end
                else
                begin
                    pp_reg <= mul_val;
                end
                overflow_reg <= overflow_reg | mul_sat;
            end
            if (cmd.finish)
            begin
                rp_reg       <= ONE_Q16;
                pp_reg       <= ONE_Q16;
                overflow_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            reps_reg <= reps_init;
            neg_reg  <= coefficient[COEFF_W-1];
            last_reg <= last_of_reaction;
            conc_reg <= concentration;
            k_reg    <= equilibrium_constant;
        end
        if (cmd.write_back)
        begin
            reps_reg <= reps_reg - COEFF_W'(1);
        end
        if (cmd.load_ops)
        begin
            acc_reg <= '0;
            if (reps_reg == '0)
            begin
                a_reg   <= clamp_one(rp_reg);
                b_reg   <= CONC_W'(k_reg);
                div_reg <= clamp_one(pp_reg);
            end
            else
            begin
                a_reg <= neg_reg ? rp_reg : pp_reg;
                b_reg <= conc_reg;
            end
        end
        else if (part_valid_reg)
        begin
            acc_reg <= acc_reg + part_shifted;
        end
        if (cmd.mul_issue)
        begin
            part_reg     <= a_half * b_half;
            part_idx_reg <= cmd.pp_idx;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= num_hi;
            lo_reg   <= {acc_reg[ACC_W-PROD_W-1:0], FRAC_W'(0)};
            q_reg    <= (num_hi >= div_reg) ? {OUT_W{1'b1}} : '0;
            qsat_reg <= (num_hi >= div_reg);
        end
        if (cmd.div_step)
        begin
            lo_reg <= {lo_reg[PROD_W-2:0], 1'b0};
            q_reg  <= {q_reg[OUT_W-2:0], sub_ok};
            rem_reg <= sub_ok ? (rem_sh[PROD_W-1:0] - div_reg) : rem_sh[PROD_W-1:0];
        end
        if (cmd.finish)
        begin
            likelihood_reg <= q_reg;
            saturated_reg  <= overflow_reg | qsat_reg;
        end
    end

    assign status.reps_zero = (reps_reg == '0);
    assign status.last_item = last_reg;
    assign status.k_mode    = k_mode_reg;
    assign status.quot_ovf  = (num_hi >= div_reg);

    assign likelihood = likelihood_reg;
    assign saturated  = saturated_reg;

endmodule : rql_dp

`default_nettype wire

### rtl/core/rql_ctrl.sv
// ----------------------------------------------------------------------------
// rql_ctrl
// Controller: sequences power steps, the constant multiply, the divider and
// the result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module rql_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire                     out_ready,
    input  rql_pkg::rql_status_t    status,
    output rql_pkg::rql_cmd_t       cmd
);
    import rql_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_MUL      = 3'd2;
    localparam logic [2:0] S_MUL_END  = 3'd3;
    localparam logic [2:0] S_WB       = 3'd4;
    localparam logic [2:0] S_DIV_INIT = 3'd5;
    localparam logic [2:0] S_DIV      = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    localparam logic [1:0] PP_LAST = 2'd3;
    localparam logic [DIV_STEPS_W-1:0] DIV_LAST = {DIV_STEPS_W{1'b1}};

    logic [2:0]             state_reg, state_next;
    logic [1:0]             pp_idx_reg, pp_idx_next;
    logic [DIV_STEPS_W-1:0] div_cnt_reg, div_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        pp_idx_next  = pp_idx_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.reps_zero || status.last_item)
                begin
                    cmd.load_ops = 1'b1;
                    pp_idx_next  = '0;
                    state_next   = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul_issue = 1'b1;
                cmd.pp_idx    = pp_idx_reg;
                pp_idx_next   = pp_idx_reg + 2'd1;
                if (pp_idx_reg == PP_LAST)
                begin
                    state_next = S_MUL_END;
                end
            end
            S_MUL_END:
            begin
                state_next = status.k_mode ? S_DIV_INIT : S_WB;
            end
            S_WB:
            begin
                cmd.write_back = 1'b1;
                state_next     = S_CHECK;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = status.quot_ovf ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_STEPS_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pp_idx_reg    <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pp_idx_reg    <= pp_idx_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : rql_ctrl

`default_nettype wire

### rtl/core/reaction_quotient_likelihood_top.sv
// ----------------------------------------------------------------------------
// reaction_quotient_likelihood_top
// An entry with |coefficient| = n (clamped to MAX_COEFF) takes n power steps:
// each power step is a check, four passes of one shared 32x32 multiplier, a drain
// and a write back. A last entry adds the constant multiply, divider setup,
// the one-bit-per-cycle divider for the 64-bit quotient (skipped when the quotient
// saturates) and the result load, which waits while an earlier result is held.
// One entry at a time; a result waits in the output register while the next
// entry is taken. Reset: idle, both products at 1.0, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module reaction_quotient_likelihood_top #(
    parameter int MAX_COEFF = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    rql_in_if.sink      item_in,
    rql_out_if.source   result_out
);
    import rql_pkg::*;

    rql_cmd_t    cmd;
    rql_status_t status;

    rql_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rql_dp #(
        .MAX_COEFF (MAX_COEFF)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .coefficient          (item_in.coefficient),
        .concentration        (item_in.concentration),
        .equilibrium_constant (item_in.equilibrium_constant),
        .last_of_reaction     (item_in.last_of_reaction),
        .likelihood           (result_out.likelihood),
        .saturated            (result_out.saturated)
    );

    // capture only on an accepted transaction
    a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture == (item_in.valid && item_in.ready))
        else $error("entry capture without accepted transaction");

    // result register never overwritten while held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(result_out.valid && !result_out.ready))
        else $error("result overwritten while pending");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> result_out.valid)
        else $error("finished result not presented");

    // zero coefficient, not last: back to ready after the check state
    a_zero_entry_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready && (item_in.coefficient == '0)
            && !item_in.last_of_reaction) |=> ##1 item_in.ready)
        else $error("empty entry did not return to idle");

endmodule : reaction_quotient_likelihood_top

`default_nettype wire
